@@ rtl/core/stdf_pkg.sv @@
// ----------------------------------------------------------------------------
// stdf_pkg
// shared types and constants of the sieve trial division factorizer
// ----------------------------------------------------------------------------
package stdf_pkg;

  localparam int VALUE_W = 32;  // width of the value and factor fields
  localparam int MULT_W  = 6;   // width of the multiplicity field

  // table build sequencer
  typedef enum logic [2:0] {
    SV_CLEAR,
    SV_READ,
    SV_TEST,
    SV_MARK,
    SV_DONE
  } sv_state_t;

  // factorization sequencer
  typedef enum logic [3:0] {
    FZ_IDLE,
    FZ_LOAD,
    FZ_SQ,
    FZ_CMP,
    FZ_DIVST,
    FZ_DIV,
    FZ_NEXT,
    FZ_END,
    FZ_PUSH,
    FZ_FLUSH
  } fz_state_t;

endpackage

@@ rtl/core/stdf_div.sv @@
// ----------------------------------------------------------------------------
// stdf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module stdf_div #(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    trial    = {r_r, q_r[NW-1]};
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      r_nxt    = '0;
      d_nxt    = den;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = DW'(trial - {1'b0, d_r});
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        r_nxt = trial[DW-1:0];
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      k_nxt = k_r + 1'b1;
      if (k_r == KW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

@@ rtl/core/stdf_sieve.sv @@
// ----------------------------------------------------------------------------
// stdf_sieve
// builds the ascending prime table after reset and serves table reads
// ----------------------------------------------------------------------------
module stdf_sieve #(
  parameter longint unsigned SIEVE_LIMIT = 65537,
  parameter longint unsigned PRIME_SLOTS = 8192
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$clog2(PRIME_SLOTS)-1:0]        rd_addr,
  output logic [$clog2(SIEVE_LIMIT+1)-1:0]      rd_data,
  output logic                                  ready,
  output logic [$clog2(PRIME_SLOTS+1)-1:0]      count
);
  import stdf_pkg::*;

  localparam int AW = $clog2(SIEVE_LIMIT + 1);
  localparam int JW = $clog2(2 * SIEVE_LIMIT + 1);
  localparam int TA = $clog2(PRIME_SLOTS);
  localparam int CW = $clog2(PRIME_SLOTS + 1);

  logic          comp_mem [SIEVE_LIMIT+1];  // composite marks
  logic [AW-1:0] tbl_mem  [PRIME_SLOTS];

  sv_state_t     state_r, state_nxt;
  logic [JW-1:0] i_r, i_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          comp_q;
  logic [AW-1:0] tbl_q;
  logic          mk_we;
  logic [AW-1:0] mk_addr;
  logic          mk_data;
  logic          tb_we;
  logic          last_i;

  assign last_i = (i_r == JW'(SIEVE_LIMIT));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SV_CLEAR: if (j_r == JW'(SIEVE_LIMIT)) state_nxt = SV_READ;
      SV_READ:  state_nxt = SV_TEST;
      SV_TEST: begin
        if (!comp_q) state_nxt = SV_MARK;
        else         state_nxt = last_i ? SV_DONE : SV_READ;
      end
      SV_MARK: begin
        if (j_r > JW'(SIEVE_LIMIT)) state_nxt = last_i ? SV_DONE : SV_READ;
      end
      SV_DONE:  state_nxt = SV_DONE;
      default:  state_nxt = SV_CLEAR;
    endcase
  end

  // datapath
  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    cnt_nxt = cnt_r;
    mk_we   = 1'b0;
    mk_addr = j_r[AW-1:0];
    mk_data = 1'b0;
    tb_we   = 1'b0;
    case (state_r)
      SV_CLEAR: begin
        mk_we = 1'b1;
        j_nxt = j_r + 1'b1;
        i_nxt = JW'(2);
      end
      SV_TEST: begin
        if (!comp_q) begin
          if (cnt_r < CW'(PRIME_SLOTS)) begin
            tb_we   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          j_nxt = i_r + i_r;
        end else if (!last_i) begin
          i_nxt = i_r + 1'b1;
        end
      end
      SV_MARK: begin
        if (j_r > JW'(SIEVE_LIMIT)) begin
          if (!last_i) i_nxt = i_r + 1'b1;
        end else begin
          mk_we   = 1'b1;
          mk_data = 1'b1;
          j_nxt   = j_r + i_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SV_CLEAR;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mk_we) comp_mem[mk_addr] <= mk_data;
    comp_q <= comp_mem[i_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tb_we) tbl_mem[cnt_r[TA-1:0]] <= i_r[AW-1:0];
    tbl_q <= tbl_mem[rd_addr];
  end

  assign rd_data = tbl_q;
  assign ready   = (state_r == SV_DONE);
  assign count   = cnt_r;

endmodule

@@ rtl/core/sieve_trial_division_factorizer_core.sv @@
// ----------------------------------------------------------------------------
// sieve_trial_division_factorizer_core
// prime factorizer: sieve-built prime table plus trial division
// ----------------------------------------------------------------------------
// usage
//   in_*  : one transaction carries a 32-bit value to factorize
//   out_* : one transaction per result item (factor, multiplicity, last);
//           last marks the final item of a value; values 0 and 1 give one
//           item with factor 0 and multiplicity 0
//   cfg_* : write of list_each_copy (0 = prime with multiplicity,
//           1 = one item per prime occurrence), taken only while idle
// reset
//   the sieve first clears its mark memory, then sieves 2..SIEVE_LIMIT,
//   reading and testing each candidate and marking the multiples of
//   each prime it finds; in_ready stays low until then
// throughput
//   one value at a time; each table prime is loaded, squared and compared
//   with the remaining value before its trial divisions in the shared
//   one-bit-per-cycle divider; a 32-bit value with a large prime cofactor
//   runs longest; in_ready is low while a value runs
// stall
//   one output register plus one pending item; a stalled receiver holds
//   the sequencer in its push or flush step, nothing is lost or dropped
// ----------------------------------------------------------------------------
module sieve_trial_division_factorizer_core #(
  parameter longint unsigned SIEVE_LIMIT = 65537,
  parameter longint unsigned PRIME_SLOTS = 8192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stdf_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stdf_pkg::VALUE_W-1:0] out_factor,
  output logic [stdf_pkg::MULT_W-1:0]  out_multiplicity,
  output logic                         out_last
);
  import stdf_pkg::*;

  localparam int PW  = $clog2(SIEVE_LIMIT + 1);   // prime width
  localparam int TA  = $clog2(PRIME_SLOTS);
  localparam int CW  = $clog2(PRIME_SLOTS + 1);
  localparam int SQW = 2 * PW + VALUE_W;          // compare width

  fz_state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic                 copy_r;
  logic [VALUE_W-1:0]   n_r, n_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [MULT_W-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]        d_r, d_nxt;
  logic [2*PW-1:0]      sq_r, sq_nxt;
  // item waiting to be pushed, and the held-back item
  logic [VALUE_W-1:0]   nf_r, nf_nxt, pf_r, pf_nxt;
  logic [MULT_W-1:0]    nm_r, nm_nxt, pm_r, pm_nxt;
  logic                 pv_r, pv_nxt;
  // output register
  logic                 ov_r, ov_nxt, ol_r, ol_nxt;
  logic [VALUE_W-1:0]   of_r, of_nxt;
  logic [MULT_W-1:0]    om_r, om_nxt;

  logic                 sv_ready;
  logic [CW-1:0]        sv_count;
  logic [PW-1:0]        tbl_q;
  logic                 div_start, div_done;
  logic [VALUE_W-1:0]   div_quo;
  logic [PW-1:0]        div_rem;
  logic                 out_free, in_acc;

  stdf_sieve #(
    .SIEVE_LIMIT (SIEVE_LIMIT),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_sieve (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (i_r[TA-1:0]),
    .rd_data (tbl_q),
    .ready   (sv_ready),
    .count   (sv_count)
  );

  stdf_div #(
    .NW (VALUE_W),
    .DW (PW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (n_r),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign cfg_ready = (state_r == FZ_IDLE);
  assign in_ready  = sv_ready && (state_r == FZ_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !ov_r || out_ready;
  assign div_start = (state_r == FZ_DIVST);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FZ_IDLE:  if (in_acc) state_nxt = (in_value < VALUE_W'(2)) ? FZ_PUSH : FZ_LOAD;
      FZ_LOAD:  state_nxt = (i_r == sv_count) ? FZ_END : FZ_SQ;
      FZ_SQ:    state_nxt = FZ_CMP;
      FZ_CMP:   state_nxt = (SQW'(sq_r) > SQW'(n_r)) ? FZ_END : FZ_DIVST;
      FZ_DIVST: state_nxt = FZ_DIV;
      FZ_DIV: begin
        if (div_done) begin
          if (div_rem == '0) state_nxt = copy_r ? FZ_PUSH : FZ_DIVST;
          else state_nxt = (!copy_r && cnt_r != '0) ? FZ_PUSH : FZ_NEXT;
        end
      end
      FZ_NEXT:  state_nxt = FZ_LOAD;
      FZ_END:   state_nxt = (n_r > VALUE_W'(1)) ? FZ_PUSH : FZ_FLUSH;
      FZ_PUSH:  if (!pv_r || out_free) state_nxt = ret_r;
      FZ_FLUSH: if (out_free) state_nxt = FZ_IDLE;
      default:  state_nxt = FZ_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt   = n_r;
    i_nxt   = i_r;
    cnt_nxt = cnt_r;
    d_nxt   = d_r;
    sq_nxt  = sq_r;
    nf_nxt  = nf_r;
    nm_nxt  = nm_r;
    ret_nxt = ret_r;
    pf_nxt  = pf_r;
    pm_nxt  = pm_r;
    pv_nxt  = pv_r;
    of_nxt  = of_r;
    om_nxt  = om_r;
    ol_nxt  = ol_r;
    ov_nxt  = ov_r && !out_ready;
    case (state_r)
      FZ_IDLE: begin
        n_nxt   = in_value;
        i_nxt   = '0;
        cnt_nxt = '0;
        nf_nxt  = '0;
        nm_nxt  = '0;
        ret_nxt = FZ_FLUSH;
      end
      FZ_SQ: begin
        d_nxt  = tbl_q;
        sq_nxt = tbl_q * tbl_q;
      end
      FZ_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            n_nxt   = div_quo;
            cnt_nxt = cnt_r + 1'b1;
            nf_nxt  = VALUE_W'(d_r);
            nm_nxt  = MULT_W'(1);
            ret_nxt = FZ_DIVST;
          end else begin
            nf_nxt  = VALUE_W'(d_r);
            nm_nxt  = cnt_r;
            ret_nxt = FZ_NEXT;
          end
        end
      end
      FZ_NEXT: begin
        i_nxt   = i_r + 1'b1;
        cnt_nxt = '0;
      end
      FZ_END: begin
        nf_nxt  = n_r;
        nm_nxt  = MULT_W'(1);
        ret_nxt = FZ_FLUSH;
      end
      FZ_PUSH: begin
        // the held item goes out once a newer one shows it is not the last
        if (!pv_r || out_free) begin
          if (pv_r) begin
            of_nxt = pf_r;
            om_nxt = pm_r;
            ol_nxt = 1'b0;
            ov_nxt = 1'b1;
          end
          pf_nxt = nf_r;
          pm_nxt = nm_r;
          pv_nxt = 1'b1;
        end
      end
      FZ_FLUSH: begin
        if (out_free) begin
          of_nxt = pf_r;
          om_nxt = pm_r;
          ol_nxt = 1'b1;
          ov_nxt = 1'b1;
          pv_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FZ_IDLE;
      ret_r   <= FZ_FLUSH;
      copy_r  <= 1'b0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) copy_r <= cfg_data;
    end
    n_r   <= n_nxt;
    i_r   <= i_nxt;
    cnt_r <= cnt_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    nf_r  <= nf_nxt;
    nm_r  <= nm_nxt;
    pf_r  <= pf_nxt;
    pm_r  <= pm_nxt;
    of_r  <= of_nxt;
    om_r  <= om_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid        = ov_r;
  assign out_factor       = of_r;
  assign out_multiplicity = om_r;
  assign out_last         = ol_r;

  // no new value while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // no value before the prime table is complete
  a_wait_for_table: assert property (@(posedge clk) disable iff (!rst_n)
    !sv_ready |-> !in_ready)
    else $error("input ready before table built");

  // the flush step always presents a final item
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FZ_FLUSH) && out_free |=> out_valid && out_last)
    else $error("flush did not present final item");

  // a held item exists whenever the flush step runs
  a_flush_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FZ_FLUSH) |-> pv_r)
    else $error("flush without held item");

endmodule

@@ bench/stdf_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stdf_result_checker
// watches the factorizer channels, predicts the factor list of every
// accepted value and compares each result transaction in order
// ----------------------------------------------------------------------------
module stdf_result_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [stdf_pkg::VALUE_W-1:0] in_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [stdf_pkg::VALUE_W-1:0] out_factor,
  input  logic [stdf_pkg::MULT_W-1:0]  out_multiplicity,
  input  logic                         out_last,
  output int                           fail_count,
  output int                           pending
);

  localparam int unsigned SIEVE_TOP  = 65537;
  localparam int unsigned SLOTS      = 8192;
  localparam int          MAX_ITEMS  = 32;

  typedef struct packed {
    logic [stdf_pkg::VALUE_W-1:0] factor;
    logic [stdf_pkg::MULT_W-1:0]  mult;
    logic                         last;
  } factor_item_t;

  factor_item_t   factor_queue[$];
  int unsigned    table_primes[$];
  bit             composite[SIEVE_TOP+1];
  logic           per_copy;

  initial begin
    fail_count = 0;
    pending    = 0;
    per_copy   = 1'b0;
    for (int unsigned i = 2; i <= SIEVE_TOP; i++) begin
      if (!composite[i]) begin
        if (table_primes.size() < SLOTS) table_primes.insert(table_primes.size(), i);
        for (int unsigned j = i + i; j <= SIEVE_TOP; j += i) composite[j] = 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void add_item(ref factor_item_t items[$], input longint unsigned f,
                                   input longint unsigned m);
    factor_item_t it;
    if (items.size() >= MAX_ITEMS) return;
    it.factor = f[stdf_pkg::VALUE_W-1:0];
    it.mult   = m[stdf_pkg::MULT_W-1:0];
    it.last   = 1'b0;
    items.insert(items.size(), it);
  endfunction

  // trial division over the stored primes
  function automatic void factorize_value(input logic [stdf_pkg::VALUE_W-1:0] v);
    longint unsigned n, d, cnt;
    factor_item_t items[$];
    n = v;
    if (n < 2) begin
      add_item(items, 0, 0);
    end else begin
      foreach (table_primes[i]) begin
        d = table_primes[i];
        if (d > n / d) break;
        cnt = 0;
        while (n % d == 0) begin
          n = n / d;
          cnt++;
          if (per_copy) add_item(items, d, 1);
        end
        if (!per_copy && cnt != 0) add_item(items, d, cnt);
      end
      if (n > 1) add_item(items, n, 1);
    end
    items[items.size()-1].last = 1'b1;
    foreach (items[i]) factor_queue.insert(factor_queue.size(), items[i]);
  endfunction

  always @(posedge clk) begin
    factor_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) per_copy = cfg_data;
      if (in_valid && in_ready) factorize_value(in_value);
      if (out_valid && out_ready) begin
        if (factor_queue.size() == 0) begin
          report_mismatch("unexpected result, factor", out_factor, 0);
        end else begin
          want = factor_queue.pop_front();
          if (out_factor !== want.factor) report_mismatch("factor", out_factor, want.factor);
          if (out_multiplicity !== want.mult)
            report_mismatch("multiplicity", out_multiplicity, want.mult);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
      pending = factor_queue.size();
    end
  end

endmodule

@@ bench/tb_sieve_trial_division_factorizer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sieve_trial_division_factorizer_core
// stimulus and verdict for the sieve trial division factorizer
// ----------------------------------------------------------------------------
// drives directed and random values through both list modes with random
// idling on both sides and one long receiver hold-off; a separate checker
// predicts every result transaction and counts mismatches
// ----------------------------------------------------------------------------
module tb_sieve_trial_division_factorizer_core;

  // sieve, two worst-case values, three random values, smooth values, ample margin
  localparam longint CYCLE_LIMIT = 20000000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic                         cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [stdf_pkg::VALUE_W-1:0] in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [stdf_pkg::VALUE_W-1:0] out_factor;
  logic [stdf_pkg::MULT_W-1:0]  out_multiplicity;
  logic                         out_last;

  int     fail_count;
  int     pending;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_len;
  int     hold_seq;      // bumped by the main process to ask for a hold-off
  int     hold_seen;
  int     hold_left;
  longint cycle_count;

  sieve_trial_division_factorizer_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_factor       (out_factor),
    .out_multiplicity (out_multiplicity),
    .out_last         (out_last)
  );

  stdf_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_factor       (out_factor),
    .out_multiplicity (out_multiplicity),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // clock, 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sieve_trial_division_factorizer_core: FAILED **");
      $finish;
    end
  end

  // receiver: random idling, or a long hold-off when one is asked for
  initial begin
    hold_seen = 0;
    hold_left = 0;
  end
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one configuration transaction, only while the block is drained
  task automatic write_list_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one input transaction; valid is dropped only when the sender idles
  task automatic send_value(input logic [stdf_pkg::VALUE_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // mostly smooth values: random small primes times a cofactor up to 2^20,
  // which keeps trial division short; a few tiny values as noise
  function automatic logic [stdf_pkg::VALUE_W-1:0] smooth_value();
    int unsigned small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    longint unsigned n;
    longint unsigned p;
    if ($urandom_range(99) < 8) return $urandom_range(0, 3);
    n = $urandom_range(1, 1 << 20);
    repeat ($urandom_range(0, 14)) begin
      p = small_primes[$urandom_range(0, 11)];
      if (n * p <= 64'hFFFF_FFFF) n = n * p;
    end
    return n[stdf_pkg::VALUE_W-1:0];
  endfunction

  task automatic send_directed(input bit with_slow);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd4);
    send_value(32'd12);
    send_value(32'hFFFF_FFFF);       // 3*5*17*257*65537
    send_value(32'h8000_0000);       // 2^31, most items in per-copy mode
    send_value(32'd65537);           // largest table prime
    send_value(32'd131042);          // 2*65521
    send_value(32'd4294967290);
    send_value(32'h5555_5555);
    send_value(32'hAAAA_AAAA);
    send_value(32'd30030);           // primorial
    if (with_slow) begin
      send_value(32'd4294967291);    // largest 32-bit prime, walks the whole table
      send_value(32'd4293001441);    // 65521 squared
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= 1'b0;
    in_valid      <= 1'b0;
    in_value      <= '0;
    out_ready     <= 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 57;
    hold_len      = 0;
    hold_seq      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: multiplicity mode, receiver idles a lot
    write_list_mode(1'b0);
    send_directed(1'b1);
    repeat (20) send_value(smooth_value());
    drain_block();

    // phase two: per-copy mode, sender idles a lot
    send_idle_pct = 57;
    recv_idle_pct = 15;
    write_list_mode(1'b1);
    send_directed(1'b0);
    repeat (20) send_value(smooth_value());
    drain_block();

    // phase three: no idling, long receiver hold-off fills the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_list_mode(1'b0);
    hold_len = 3000;
    hold_seq <= hold_seq + 1;
    repeat (20) send_value(smooth_value());
    repeat (3) send_value($urandom());
    drain_block();

    // phase four: per-copy mode again, no idling
    write_list_mode(1'b1);
    repeat (15) send_value(smooth_value());
    send_value(32'h8000_0000);
    drain_block();

    if (fail_count == 0) begin
      $display("** sieve_trial_division_factorizer_core: PASSED **");
    end else begin
      $display("** sieve_trial_division_factorizer_core: FAILED **");
    end
    $finish;
  end

endmodule
